>>> hw/rtl/dcd_pkg.sv
// Shared types, constants and register codes of the detection cell decoder.
package dcd_pkg;

  // Layer limits
  localparam int MAX_CLASSES   = 80;
  localparam int GRID_MAX      = 128;
  localparam int ANCHORS       = 3;

  // Vector layout
  localparam int HEAD_CHANNELS = 5;
  localparam int COUNT_LIMIT   = 127;
  localparam int CLASS_CAP     = 122;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THRESHOLD = 3'd0,
    REG_ZERO_POINT     = 3'd1,
    REG_QUANT_SCALE    = 3'd2,
    REG_GRID_STRIDE    = 3'd3,
    REG_CLASS_COUNT    = 3'd4,
    REG_ANCHOR_TABLE   = 3'd5
  } cfg_reg_e;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [7:0]  zero_point;
    logic [15:0] quant_scale;
    logic [7:0]  grid_stride;
    logic [6:0]  class_count;
    logic [59:0] anchor_table;
  } dcd_cfg_t;

  // One complete cell vector, handed from front to back
  typedef struct packed {
    logic [7:0] box_x;
    logic [7:0] box_y;
    logic [7:0] box_w;
    logic [7:0] box_h;
    logic [7:0] obj;
    logic [7:0] best;
    logic [6:0] cls;
    logic [6:0] row;
    logic [6:0] col;
    logic [1:0] anchor;
  } dcd_job_t;

endpackage

>>> hw/rtl/detection_cell_decode_unit.sv
// Top level of the detection cell decoder: configuration registers, front, queue, back.
//
// Channel values of one grid cell and anchor stream in one beat per cycle: tx, ty, tw,
// th, objectness, then the class scores; the beat with tlast closes the vector. The
// front takes a beat every cycle while the job queue has room, and a complete vector
// becomes one job. The back steps through load, three multiply steps and finish for each
// job and gives at most one result: the corner box in Q15.8 pixels, the score in Q8.16
// and the first maximal class, or nothing if the cell falls below the confidence
// threshold. A complete vector is at least six beats long, so with the detection stream
// ready the input never stalls; while a detection waits for tready the back holds in its
// finish cycle, and the input stalls once QUEUE_DEPTH jobs are queued. Configuration must
// be written only while the block is idle; the block does not enforce this.
module detection_cell_decode_unit
  import dcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Channel value stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // raw_value[7:0], cell_row[14:8], cell_col[21:15]
  input  logic [1:0]            s_axis_tuser,   // anchor_sel[1:0]
  input  logic                  s_axis_tlast,   // last_value
  // Detection stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // box_left[23:0], box_top[47:24], box_width[70:48], box_height[93:71],
  // score[117:94], class index[124:118]
  output logic [127:0]          m_axis_tdata
);

  dcd_cfg_t cfg_q;
  dcd_job_t push_data, pop_data;
  logic     push, full, pop, empty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_threshold <= 16'd16384;
      cfg_q.zero_point     <= 8'd0;
      cfg_q.quant_scale    <= 16'd65535;
      cfg_q.grid_stride    <= 8'd8;
      cfg_q.class_count    <= 7'd80;
      cfg_q.anchor_table   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data_i[15:0];
        REG_ZERO_POINT:     cfg_q.zero_point     <= cfg_data_i[7:0];
        REG_QUANT_SCALE:    cfg_q.quant_scale    <= cfg_data_i[15:0];
        REG_GRID_STRIDE:    cfg_q.grid_stride    <= cfg_data_i[7:0];
        REG_CLASS_COUNT:    cfg_q.class_count    <= cfg_data_i[6:0];
        REG_ANCHOR_TABLE:   cfg_q.anchor_table   <= cfg_data_i[59:0];
        default: ;
      endcase
    end
  end

  dcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .beat_valid_i (s_axis_tvalid),
    .beat_ready_o (s_axis_tready),
    .raw_value_i  (s_axis_tdata[7:0]),
    .cell_row_i   (s_axis_tdata[14:8]),
    .cell_col_i   (s_axis_tdata[21:15]),
    .anchor_sel_i (s_axis_tuser),
    .last_value_i (s_axis_tlast),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (full)
  );

  dcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (!empty),
    .job_i         (pop_data),
    .job_pop_o     (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/dcd_queue.sv
// Small job queue that decouples the classifying front from the decoding back.
module dcd_queue
  import dcd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dcd_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output dcd_job_t pop_data_o,
  output logic     empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  dcd_job_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/dcd_front.sv
// Front end: takes channel beats, keeps box values and the running class maximum.
module dcd_front
  import dcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dcd_cfg_t    cfg_i,
  input  logic        beat_valid_i,
  output logic        beat_ready_o,
  input  logic [7:0]  raw_value_i,
  input  logic [6:0]  cell_row_i,
  input  logic [6:0]  cell_col_i,
  input  logic [1:0]  anchor_sel_i,
  input  logic        last_value_i,
  output logic        push_o,
  output dcd_job_t    push_data_o,
  input  logic        queue_full_i
);

  localparam int ClassLimI = (MAX_CLASSES < CLASS_CAP) ? MAX_CLASSES : CLASS_CAP;
  localparam logic [6:0] ClassLim = 7'(ClassLimI);
  localparam logic [6:0] Head     = 7'(HEAD_CHANNELS);
  localparam logic [6:0] CntMax   = 7'(COUNT_LIMIT);

  logic [6:0] cnt_q, cnt_d;
  logic [6:0] idx_q, idx_d;
  logic [7:0] box_q [4];
  logic [7:0] obj_q;
  logic [7:0] best_q, best_d;
  logic [6:0] nclass;
  logic [6:0] need;
  logic       complete;
  logic       beat;

  assign beat_ready_o = !queue_full_i;
  assign beat         = beat_valid_i && beat_ready_o;

  // Effective class count and vector length
  always_comb begin
    nclass = cfg_i.class_count;
    if (nclass == '0) begin
      nclass = 7'd1;
    end
    if (nclass > ClassLim) begin
      nclass = ClassLim;
    end
    need = Head + nclass;
  end

  assign complete = ({1'b0, cnt_q} + 8'd1) >= {1'b0, need};

  // Running first strict maximum over the class values
  always_comb begin
    best_d = best_q;
    idx_d  = idx_q;
    if (cnt_q == Head) begin
      best_d = raw_value_i;
      idx_d  = '0;
    end else if (cnt_q > Head && cnt_q < need &&
                 $signed(raw_value_i) > $signed(best_q)) begin
      best_d = raw_value_i;
      idx_d  = cnt_q - Head;
    end
  end

  // Channel counter, saturating, cleared at the end of a vector
  always_comb begin
    cnt_d = (cnt_q < CntMax) ? cnt_q + 1'b1 : CntMax;
    if (last_value_i) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (beat) begin
      cnt_q <= cnt_d;
      idx_q <= last_value_i ? '0 : idx_d;
    end
  end

  // Captured channel values
  always_ff @(posedge clk_i) begin
    if (beat) begin
      if (cnt_q < 7'd4) begin
        box_q[cnt_q[1:0]] <= raw_value_i;
      end
      if (cnt_q == 7'd4) begin
        obj_q <= raw_value_i;
      end
      best_q <= best_d;
    end
  end

  // A complete vector becomes a job
  assign push_o = beat && last_value_i && complete;

  always_comb begin
    push_data_o.box_x  = box_q[0];
    push_data_o.box_y  = box_q[1];
    push_data_o.box_w  = box_q[2];
    push_data_o.box_h  = box_q[3];
    push_data_o.obj    = obj_q;
    push_data_o.best   = best_d;
    push_data_o.cls    = idx_d;
    push_data_o.row    = cell_row_i;
    push_data_o.col    = cell_col_i;
    push_data_o.anchor = anchor_sel_i;
  end

endmodule

>>> hw/rtl/dcd_back.sv
// Back end: dequantizes a job, decodes the box, applies the threshold, drives results.
module dcd_back
  import dcd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcd_cfg_t      cfg_i,
  input  logic          job_valid_i,
  input  dcd_job_t      job_i,
  output logic          job_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StMul3 = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  localparam logic [10:0] GridLast   = 11'(GRID_MAX - 1);
  localparam logic [1:0]  AnchorLast = 2'(ANCHORS - 1);

  logic [2:0] state_q, state_d;

  // Job capture
  logic signed [8:0] dx_q, dy_q, dw_q, dh_q, do_q, db_q;
  logic [6:0]        row_q, col_q, cls_q;
  logic [9:0]        aw_q, ah_q;
  logic [6:0]        row_c, col_c;
  logic [1:0]        anc_c;
  logic [9:0]        aw_c, ah_c;

  // Products
  logic signed [16:0] scale_s;
  logic signed [25:0] obj_q, bc_q, tx_q, ty_q;
  logic [31:0]        s2_q;
  logic [15:0]        dw2_q, dh2_q;
  logic signed [17:0] dw2_m, dh2_m;
  logic signed [51:0] prod_q;
  logic signed [27:0] ux, uy;
  logic signed [36:0] cx_q, cy_q;
  logic [47:0]        pw_q, ph_q;
  logic [57:0]        w_q, h_q;

  // Finish stage
  logic signed [61:0] diff_x, diff_y;
  logic signed [36:0] lx, ly;
  logic [35:0]        wv, hv;
  logic signed [35:0] sv;
  logic [23:0]        left_v, top_v, score_v;
  logic [22:0]        width_v, height_v;
  logic               pass;
  logic               out_free;
  logic               load_out;
  logic               out_valid_q;
  logic [127:0]       out_data_q;

  function automatic logic signed [8:0] dq_diff(input logic [7:0] v, input logic [7:0] zp);
    dq_diff = $signed({v[7], v}) - $signed({zp[7], zp});
  endfunction

  function automatic logic [23:0] sat_s24(input logic signed [36:0] v);
    if (v > 37'sd8388607) begin
      sat_s24 = 24'h7FFFFF;
    end else if (v < -37'sd8388608) begin
      sat_s24 = 24'h800000;
    end else begin
      sat_s24 = v[23:0];
    end
  endfunction

  function automatic logic [22:0] sat_u23(input logic [35:0] v);
    sat_u23 = (v > 36'd8388607) ? 23'h7FFFFF : v[22:0];
  endfunction

  // Clamp cell position and pick the anchor
  always_comb begin
    row_c = ({4'b0, job_i.row} > GridLast) ? GridLast[6:0] : job_i.row;
    col_c = ({4'b0, job_i.col} > GridLast) ? GridLast[6:0] : job_i.col;
    anc_c = (job_i.anchor > AnchorLast) ? AnchorLast : job_i.anchor;
    case (anc_c)
      2'd0: begin
        aw_c = cfg_i.anchor_table[9:0];
        ah_c = cfg_i.anchor_table[19:10];
      end
      2'd1: begin
        aw_c = cfg_i.anchor_table[29:20];
        ah_c = cfg_i.anchor_table[39:30];
      end
      default: begin
        aw_c = cfg_i.anchor_table[49:40];
        ah_c = cfg_i.anchor_table[59:50];
      end
    endcase
  end

  assign job_pop_o = (state_q == StIdle) && job_valid_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (job_valid_i) state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StFin;
      StFin: begin
        if (!pass || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Step products
  assign scale_s = $signed({1'b0, cfg_i.quant_scale});
  assign dw2_m   = dw_q * dw_q;
  assign dh2_m   = dh_q * dh_q;
  assign ux      = (28'(tx_q) <<< 1) - 28'sd32768 + $signed({5'b0, col_q, 16'b0});
  assign uy      = (28'(ty_q) <<< 1) - 28'sd32768 + $signed({5'b0, row_q, 16'b0});

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        dx_q  <= dq_diff(job_i.box_x, cfg_i.zero_point);
        dy_q  <= dq_diff(job_i.box_y, cfg_i.zero_point);
        dw_q  <= dq_diff(job_i.box_w, cfg_i.zero_point);
        dh_q  <= dq_diff(job_i.box_h, cfg_i.zero_point);
        do_q  <= dq_diff(job_i.obj, cfg_i.zero_point);
        db_q  <= dq_diff(job_i.best, cfg_i.zero_point);
        row_q <= row_c;
        col_q <= col_c;
        cls_q <= job_i.cls;
        aw_q  <= aw_c;
        ah_q  <= ah_c;
      end
      StMul1: begin
        obj_q <= do_q * scale_s;
        bc_q  <= db_q * scale_s;
        tx_q  <= dx_q * scale_s;
        ty_q  <= dy_q * scale_s;
        s2_q  <= cfg_i.quant_scale * cfg_i.quant_scale;
        dw2_q <= dw2_m[15:0];
        dh2_q <= dh2_m[15:0];
      end
      StMul2: begin
        prod_q <= obj_q * bc_q;
        cx_q   <= ux * $signed({1'b0, cfg_i.grid_stride});
        cy_q   <= uy * $signed({1'b0, cfg_i.grid_stride});
        pw_q   <= s2_q * dw2_q;
        ph_q   <= s2_q * dh2_q;
      end
      StMul3: begin
        w_q <= pw_q * aw_q;
        h_q <= ph_q * ah_q;
      end
      default: ;
    endcase
  end

  // Corner box, sizes, score and the threshold test
  always_comb begin
    diff_x   = (62'(cx_q) <<< 17) - $signed({2'b0, w_q, 2'b0});
    diff_y   = (62'(cy_q) <<< 17) - $signed({2'b0, h_q, 2'b0});
    lx       = diff_x[61:25];
    ly       = diff_y[61:25];
    left_v   = sat_s24(lx);
    top_v    = sat_s24(ly);
    wv       = w_q[57:22];
    hv       = h_q[57:22];
    width_v  = sat_u23(wv);
    height_v = sat_u23(hv);
    sv       = prod_q[51:16];
    if (sv < 36'sd0) begin
      score_v = '0;
    end else if (sv > 36'sd16777215) begin
      score_v = 24'hFFFFFF;
    end else begin
      score_v = sv[23:0];
    end
    pass = (obj_q >= $signed({10'b0, cfg_i.conf_threshold})) &&
           (prod_q >= $signed({20'b0, cfg_i.conf_threshold, 16'b0}));
  end

  // Output register
  assign out_free = !out_valid_q || m_axis_tready;
  assign load_out = (state_q == StFin) && pass && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {3'b0, cls_q, score_v, height_v, width_v, top_v, left_v};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
